// ===== rtl/core/wtp_pkg.sv =====
// Shared constants, height table and grid helpers for the waveform trace plotter.
`timescale 1ns / 1ps
`default_nettype none

package wtp_pkg;

  localparam int COLUMNS_DEFAULT = 320;

  localparam int COL_W    = 9;
  localparam int SAMPLE_W = 8;
  localparam int HEIGHT_W = 8;
  localparam int ROW_W    = 8;
  localparam int COLOR_W  = 16;

  // configuration register indexes
  localparam int CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] REG_HOLD        = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_TRACE_COLOR = 1'd1;

  localparam logic [COLOR_W-1:0] COLOR_WHITE       = 16'hFFFF;
  localparam logic [COLOR_W-1:0] COLOR_GREY        = 16'h4208;
  localparam logic [COLOR_W-1:0] COLOR_BLACK       = 16'h0000;
  localparam logic [COLOR_W-1:0] TRACE_COLOR_RESET = 16'hFFE0;

  localparam logic [ROW_W-1:0]    BOTTOM_ROW  = 8'd219;
  localparam logic [HEIGHT_W-1:0] FULL_HEIGHT = 8'd200;
  localparam logic [HEIGHT_W-1:0] MID_HEIGHT  = 8'd100;

  typedef logic [HEIGHT_W-1:0] height_lut_t [256];

  // height = round-half-up(sample * 200 / 255), folded into one division
  function automatic height_lut_t build_height_lut();
    height_lut_t lut;
    for (int i = 0; i < 256; i++) begin
      lut[i] = HEIGHT_W'((i * 400 + 255) / 510);
    end
    return lut;
  endfunction

  localparam height_lut_t HEIGHT_LUT = build_height_lut();

  // v % 20 == 0 for v < 512: low two bits clear and (v >> 2) divisible by 5,
  // with the divide by 5 done as a multiply by 205/1024
  function automatic logic is_mult20(input logic [COL_W-1:0] v);
    logic [14:0] prod;
    logic [4:0]  q;
    logic [6:0]  q5;
    prod = 15'(v[8:2]) * 15'd205;
    q    = prod[14:10];
    q5   = 7'({2'b00, q} * 7'd5);
    return (v[1:0] == 2'b00) && (q5 == v[8:2]);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/wtp_ram.sv =====
// Generic simple dual-port RAM, read-first, registered read.
`timescale 1ns / 1ps
`default_nettype none

module wtp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 320
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // a read at the written address returns the old contents
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/waveform_trace_plotter.sv =====
// Top level of the waveform trace plotter: height memory, erase/draw sequencer, output register.
//
//   channel  | handshake            | payload
//   ---------+----------------------+-------------------------------------------
//   in       | in_valid / in_stall  | column, sample, frame_end
//   out      | out_valid / out_stall| pixel_x, pixel_y, pixel_color, run_last
//   cfg      | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// An erasing sample gives an erase word, then a draw word; a first-frame sample only a draw word.
// The rate is set by the single output register, one pixel word per cycle if not stalled.
// The height memory is written when an in-range sample is accepted outside hold, and read
// in the same cycle (old contents), so back-to-back samples on one column need no forwarding.
// rst clears control state only; the height memory is not cleared.
// out_stall backs up through the sequencer into in_stall within the same cycle.
`timescale 1ns / 1ps
`default_nettype none

module waveform_trace_plotter #(
  parameter int COLUMNS = wtp_pkg::COLUMNS_DEFAULT
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [wtp_pkg::COL_W-1:0]       column,
  input  wire logic [wtp_pkg::SAMPLE_W-1:0]    sample,
  input  wire logic                            frame_end,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic      [wtp_pkg::COL_W-1:0]       pixel_x,
  output logic      [wtp_pkg::ROW_W-1:0]       pixel_y,
  output logic      [wtp_pkg::COLOR_W-1:0]     pixel_color,
  output logic                                 run_last,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [wtp_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [wtp_pkg::COLOR_W-1:0]     cfg_data
);

  import wtp_pkg::*;

  localparam int AW = $clog2(COLUMNS);

  // configuration
  logic               hold;
  logic [COLOR_W-1:0] trace_color;

  logic have_prev;

  // sequencer stage
  logic                s1_valid;
  logic                s1_erase;
  logic [COL_W-1:0]    s1_col;
  logic [HEIGHT_W-1:0] s1_h;
  logic                s1_x_white;
  logic                s1_x_grid;

  logic                in_fire;
  logic                take;
  logic                in_range;
  logic [AW-1:0]       addr;
  logic [HEIGHT_W-1:0] new_h;
  logic [HEIGHT_W-1:0] ram_rdata;

  logic                out_load;
  logic                s1_done;
  logic [HEIGHT_W-1:0] old_h;
  logic [HEIGHT_W-1:0] grid_row;
  logic [COLOR_W-1:0]  erase_color;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold        <= 1'b0;
      trace_color <= TRACE_COLOR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_HOLD:        hold        <= cfg_data[0];
        REG_TRACE_COLOR: trace_color <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_range = (32'(column) < COLUMNS);
  assign addr     = AW'(column);
  assign new_h    = HEIGHT_LUT[sample];

  assign out_load = s1_valid && (!out_valid || !out_stall);
  assign s1_done  = out_load && !s1_erase;
  assign in_stall = s1_valid && !s1_done;
  assign in_fire  = in_valid && !in_stall;
  assign take     = in_fire && !hold && in_range;

  wtp_ram #(
    .WIDTH (HEIGHT_W),
    .DEPTH (COLUMNS)
  ) u_height_ram (
    .clk   (clk),
    .we    (take),
    .waddr (addr),
    .wdata (new_h),
    .re    (take),
    .raddr (addr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      have_prev <= 1'b0;
      s1_valid  <= 1'b0;
      s1_erase  <= 1'b0;
    end else begin
      if (take && frame_end) begin
        have_prev <= 1'b1;
      end
      if (take) begin
        s1_valid <= 1'b1;
        s1_erase <= have_prev;
      end else if (s1_done) begin
        s1_valid <= 1'b0;
      end else if (out_load) begin
        s1_erase <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_col     <= column;
      s1_h       <= new_h;
      s1_x_white <= (column == '0) || (32'(column) == COLUMNS - 1) ||
                    (32'(column) == COLUMNS / 2);
      s1_x_grid  <= is_mult20(column);
    end
  end

  // grid color under the old trace pixel
  always_comb begin
    old_h    = (ram_rdata > FULL_HEIGHT) ? FULL_HEIGHT : ram_rdata;
    grid_row = FULL_HEIGHT - old_h;
    if (s1_x_white || grid_row == '0 || grid_row == MID_HEIGHT ||
        grid_row == FULL_HEIGHT) begin
      erase_color = COLOR_WHITE;
    end else if (s1_x_grid || is_mult20({1'b0, grid_row})) begin
      erase_color = COLOR_GREY;
    end else begin
      erase_color = COLOR_BLACK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      pixel_x <= s1_col;
      if (s1_erase) begin
        pixel_y     <= BOTTOM_ROW - old_h;
        pixel_color <= erase_color;
        run_last    <= 1'b0;
      end else begin
        pixel_y     <= BOTTOM_ROW - s1_h;
        pixel_color <= trace_color;
        run_last    <= 1'b1;
      end
    end
  end

`ifndef NO_ASSERTIONS
  // an erase is only ever pending once a sample with frame_end has been taken
  a_erase_after_frame: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1_erase |-> have_prev)
    else $error("erase pending before first frame completed");

  // once an erase word leaves, its draw word is loaded behind it
  a_draw_follows_erase: assert property (@(posedge clk) disable iff (rst)
    out_valid && !run_last && !out_stall |=> out_valid && run_last)
    else $error("draw word did not follow erase word");

  // sequencer moves from erase to draw without dropping the sample
  a_erase_then_draw: assert property (@(posedge clk) disable iff (rst)
    out_load && s1_erase |=> s1_valid && !s1_erase)
    else $error("sequencer lost sample after erase");

  // every pixel word lands inside the plot area
  a_row_in_plot: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (pixel_y >= 8'd19) && (pixel_y <= BOTTOM_ROW))
    else $error("pixel row outside plot area");
`endif

endmodule

`default_nettype wire

// ===== sim/pixel_write_checker.sv =====
// Pixel write checker: predicts erase/draw words from accepted samples and compares them.
`timescale 1ns / 1ps

module pixel_write_checker #(
  parameter int COLUMNS = wtp_pkg::COLUMNS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  logic [wtp_pkg::COL_W-1:0]       column,
  input  logic [wtp_pkg::SAMPLE_W-1:0]    sample,
  input  logic                            frame_end,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  logic [wtp_pkg::COL_W-1:0]       pixel_x,
  input  logic [wtp_pkg::ROW_W-1:0]       pixel_y,
  input  logic [wtp_pkg::COLOR_W-1:0]     pixel_color,
  input  logic                            run_last,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [wtp_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [wtp_pkg::COLOR_W-1:0]     cfg_data,
  output int                              fail_count,
  output int                              pending_words,
  output int                              words_checked,
  output int                              words_erased
);
  import wtp_pkg::*;

  typedef struct {
    logic [COL_W-1:0]   x;
    logic [ROW_W-1:0]   y;
    logic [COLOR_W-1:0] color;
    logic               last;
  } pixel_word_t;

  pixel_word_t        expected_pixels[$];
  logic [7:0]         trace_heights [COLUMNS];
  logic               frame_drawn;
  logic               display_frozen;
  logic [COLOR_W-1:0] pen_color;

  initial begin
    fail_count    = 0;
    pending_words = 0;
    words_checked = 0;
    words_erased  = 0;
  end

  // round-half-up of s*200/255, done on the doubled scale
  function automatic int trace_height(input logic [SAMPLE_W-1:0] s);
    int t;
    t = (int'(s) * 400) / 255;
    t = t + (t & 1);
    return t >> 1;
  endfunction

  function automatic logic [COLOR_W-1:0] grid_shade(input int x, input int g);
    if (x == 0 || x == COLUMNS - 1 || x == COLUMNS / 2) return COLOR_WHITE;
    if (g == 0 || g == 100 || g == 200) return COLOR_WHITE;
    if ((x % 20) != 0 && (g % 20) != 0) return COLOR_BLACK;
    return COLOR_GREY;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    fail_count++;
  endtask

  task automatic expect_word(input int x, input int y, input logic [COLOR_W-1:0] c,
                             input logic last);
    pixel_word_t w;
    w.x     = x[COL_W-1:0];
    w.y     = y[ROW_W-1:0];
    w.color = c;
    w.last  = last;
    expected_pixels.push_back(w);
  endtask

  always @(posedge clk) begin
    pixel_word_t w;
    int h;
    int old;
    if (rst) begin
      expected_pixels.delete();
      frame_drawn    = 1'b0;
      display_frozen = 1'b0;
      pen_color      = TRACE_COLOR_RESET;
    end else begin
      // output word first: it can never stem from a sample taken at this edge
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        if (expected_pixels.size() == 0) begin
          report_mismatch($sformatf("unexpected word x=%0d y=%0d color=%h last=%b",
                                    pixel_x, pixel_y, pixel_color, run_last));
        end else begin
          w = expected_pixels.pop_front();
          if (pixel_x !== w.x)
            report_mismatch($sformatf("pixel_x %0d, want %0d", pixel_x, w.x));
          if (pixel_y !== w.y)
            report_mismatch($sformatf("pixel_y %0d, want %0d (x=%0d)", pixel_y, w.y, w.x));
          if (pixel_color !== w.color)
            report_mismatch($sformatf("pixel_color %h, want %h (x=%0d)",
                                      pixel_color, w.color, w.x));
          if (run_last !== w.last)
            report_mismatch($sformatf("run_last %b, want %b (x=%0d)", run_last, w.last, w.x));
          words_checked++;
          if (!w.last) words_erased++;
        end
      end

      if (in_valid === 1'b1 && in_stall === 1'b0) begin
        if (!display_frozen && column < COLUMNS) begin
          h = trace_height(sample);
          if (frame_drawn) begin
            old = trace_heights[column];
            if (old > 200) old = 200;
            expect_word(column, 219 - old, grid_shade(column, 200 - old), 1'b0);
          end
          expect_word(column, 219 - h, pen_color, 1'b1);
          trace_heights[column] = h[7:0];
          if (frame_end) frame_drawn = 1'b1;
        end
      end

      if (cfg_valid === 1'b1 && cfg_ready === 1'b1) begin
        case (cfg_index)
          REG_HOLD:        display_frozen = cfg_data[0];
          REG_TRACE_COLOR: pen_color      = cfg_data;
          default: ;
        endcase
      end
    end
    pending_words = expected_pixels.size();
  end

endmodule

// ===== sim/testbench.sv =====
// Testbench top: drives samples and register writes into the trace plotter and gives the verdict.
`timescale 1ns / 1ps

module testbench;
  import wtp_pkg::*;

  localparam int COLUMNS      = COLUMNS_DEFAULT;
  localparam int TAIL_CYCLES  = 8;
  localparam int LIMIT_CYCLES = 400000;

  logic                   clk         = 1'b0;
  logic                   rst         = 1'b1;
  logic                   in_valid    = 1'b0;
  logic                   in_stall;
  logic [COL_W-1:0]       column      = '0;
  logic [SAMPLE_W-1:0]    sample      = '0;
  logic                   frame_end   = 1'b0;
  logic                   out_valid;
  logic                   out_stall   = 1'b0;
  logic [COL_W-1:0]       pixel_x;
  logic [ROW_W-1:0]       pixel_y;
  logic [COLOR_W-1:0]     pixel_color;
  logic                   run_last;
  logic                   cfg_valid   = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index   = '0;
  logic [COLOR_W-1:0]     cfg_data    = '0;

  int fail_count;
  int pending_words;
  int words_checked;
  int words_erased;

  int sender_gap_max = 6;
  int sink_wait_max  = 6;
  int long_hold_req  = 0;
  int sweep_col      = 0;
  int samples_sent   = 0;
  int cycle_count    = 0;

  waveform_trace_plotter #(.COLUMNS(COLUMNS)) uut (.*);

  pixel_write_checker #(.COLUMNS(COLUMNS)) u_pixel_checker (.*);

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d words still expected", cycle_count,
               pending_words);
      $display("== FAIL ==");
      $finish;
    end
  end

  // pixel word sink: random stall per word, or one long hold-off when asked
  initial begin : pixel_sink
    int n;
    wait (rst == 1'b0);
    forever begin
      if (long_hold_req > 0) begin
        n = long_hold_req;
        long_hold_req = 0;
      end else begin
        n = $urandom_range(0, sink_wait_max);
      end
      @(negedge clk);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
    end
  end

  task automatic send_sample(input int col, input int smp, input logic fend);
    int gap;
    gap = $urandom_range(0, sender_gap_max);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  <= 1'b1;
    column    <= col[COL_W-1:0];
    sample    <= smp[SAMPLE_W-1:0];
    frame_end <= fend;
    do @(posedge clk); while (in_stall !== 1'b0);
    samples_sent++;
  endtask

  task automatic drain_block();
    @(negedge clk);
    in_valid <= 1'b0;
    wait (pending_words == 0);
    // ignored samples may still be in flight
    repeat (TAIL_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [COLOR_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_random_item();
    int pick;
    int col;
    int smp;
    logic fend;
    pick = $urandom_range(0, 9);
    smp  = $urandom_range(0, 255);
    if (pick == 0) begin
      col  = $urandom_range(COLUMNS, 511);
      fend = $urandom_range(0, 1);
    end else if (pick <= 6) begin
      // in-order column sweep, frame_end on the last column
      col       = sweep_col;
      fend      = (sweep_col == COLUMNS - 1);
      sweep_col = (sweep_col + 1) % COLUMNS;
    end else begin
      col  = $urandom_range(0, COLUMNS - 1);
      fend = ($urandom_range(0, 7) == 0);
    end
    send_sample(col, smp, fend);
  endtask

  initial begin : stimulus
    int smp;
    int n_items;
    repeat (3) @(negedge clk);
    rst <= 1'b0;

    // first frame not yet complete: draws only
    send_sample(0, 0, 1'b0);
    send_sample(COLUMNS - 1, 255, 1'b0);
    send_sample(COLUMNS / 2, 127, 1'b0);
    send_sample(COLUMNS, 13, 1'b1);      // out of range, frame_end must not count
    send_sample(511, 255, 1'b1);
    drain_block();
    write_reg(REG_HOLD, {15'($urandom), 1'b1});
    send_sample(5, 100, 1'b1);           // frozen, frame_end ignored
    send_sample(0, 255, 1'b1);
    drain_block();
    write_reg(REG_HOLD, {15'($urandom), 1'b0});
    write_reg(REG_TRACE_COLOR, 16'h0000);
    send_sample(1, 1, 1'b0);

    // full first frame; a few columns get heights that land on grid lines
    for (int c = 0; c < COLUMNS; c++) begin
      case (c)
        0:           smp = 0;
        20:          smp = 255;
        40:          smp = 127;
        45:          smp = 102;
        47:          smp = 50;
        COLUMNS / 2: smp = 64;
        COLUMNS - 1: smp = 200;
        default:     smp = $urandom_range(0, 255);
      endcase
      send_sample(c, smp, c == COLUMNS - 1);
    end
    drain_block();
    write_reg(REG_TRACE_COLOR, 16'hFFFF);

    // erase then draw
    send_sample(0, 255, 1'b0);
    send_sample(20, 0, 1'b0);
    send_sample(40, 1, 1'b0);
    send_sample(45, 37, 1'b0);
    send_sample(47, 255, 1'b0);
    send_sample(47, 0, 1'b0);            // same column back to back
    send_sample(COLUMNS / 2, 128, 1'b0);
    send_sample(61, 127, 1'b0);
    send_sample(COLUMNS - 1, 255, 1'b1);
    send_sample(COLUMNS + 7, 0, 1'b0);

    for (int phase = 0; phase < 8; phase++) begin
      drain_block();
      sender_gap_max = 6;
      sink_wait_max  = 6;
      n_items        = 90;
      case (phase)
        0: begin
          write_reg(REG_TRACE_COLOR, 16'h0000);
          sender_gap_max = 0;
          sink_wait_max  = 0;
        end
        1: begin
          write_reg(REG_TRACE_COLOR, 16'hFFFF);
          sender_gap_max = 0;
          long_hold_req  = 300;
        end
        2: begin
          write_reg(REG_HOLD, {15'($urandom), 1'b1});
          n_items = 40;
        end
        3: begin
          write_reg(REG_HOLD, {15'($urandom), 1'b0});
          write_reg(REG_TRACE_COLOR, 16'($urandom));
        end
        default: write_reg(REG_TRACE_COLOR, 16'($urandom));
      endcase
      for (int i = 0; i < n_items; i++) begin
        if (phase == 3 && i == n_items / 2) drain_block();
        send_random_item();
      end
    end

    drain_block();
    $display("Offered %0d samples across frozen, burst, back-pressure and random phases.",
             samples_sent);
    $display("Compared %0d pixel words, %0d of them grid restores.", words_checked,
             words_erased);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/wtp_pkg.sv
rtl/core/wtp_ram.sv
rtl/core/waveform_trace_plotter.sv
sim/pixel_write_checker.sv
sim/testbench.sv
